// File: hdl/ets_pkg.sv
`default_nettype none

package ets_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic CMD_FRAME_EVENT = 1'b0;
	localparam logic CMD_ENCODED     = 1'b1;

	localparam logic CFG_TIMESTAMP_HALVING = 1'b0;
	localparam logic CFG_OFFSET_HALVING    = 1'b1;

	typedef logic [1:0] status_t;

	localparam status_t ST_OK          = 2'd0;
	localparam status_t ST_MISSED_GAP  = 2'd1;
	localparam status_t ST_MISSED_BUMP = 2'd2;
	localparam status_t ST_OVERFLOW    = 2'd3;

	typedef struct packed {
		logic        command;
		logic [31:0] frame_id;
		logic        skip_flag;
		logic [15:0] frame_gap;
		logic [31:0] dts_in;
		logic [31:0] pts_in;
	} item_t;

	typedef struct packed {
		logic ts_halving;
		logic off_halving;
	} cfg_t;

	typedef struct packed {
		logic        has_result;
		logic        encoded;
		status_t     status;
		logic        bump_hit;
		logic [31:0] offset;
	} verdict_t;

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(p + 1'b1);
	endfunction

	// signed divide by two, rounding toward zero
	function automatic logic [31:0] halve_signed(input logic [31:0] x);
		logic [31:0] t;
		t = x + {31'b0, x[31]};
		return {t[31], t[31:1]};
	endfunction

endpackage

`default_nettype wire

// File: hdl/encoder_timestamp_corrector_top.sv
// channel  | handshake              | payload
// ---------+------------------------+-----------------------------------------------
// in       | in_valid / in_stall    | command frame_id skip_flag frame_gap dts_in pts_in
// out      | out_valid / out_stall  | dts_out pts_out status
// config   | cfg_wr_en              | cfg_index cfg_data
//
// An accepted word passes the input register, then queue head compare, offset add
// and timestamp adds into the output register.
// One word per cycle sustained while out_stall holds no result; frame events without overflow give no result.
// Reset clears counters, offset, queue pointers and config; queue entries are not cleared.
// out_stall holds a valid output register and, with the input register full, stalls the input stage in the same cycle.
`default_nettype none

module encoder_timestamp_corrector_top (
	input  wire logic               clk,
	input  wire logic               arst_n,

	input  wire logic               cfg_wr_en,
	input  wire logic               cfg_index,
	input  wire logic               cfg_data,

	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               command,
	input  wire logic [31:0]        frame_id,
	input  wire logic               skip_flag,
	input  wire logic [15:0]        frame_gap,
	input  wire logic signed [31:0] dts_in,
	input  wire logic signed [31:0] pts_in,

	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      dts_out,
	output logic signed [31:0]      pts_out,
	output logic [1:0]              status
);
	import ets_pkg::*;

	cfg_t        cfg_q;
	logic        valid_s1;
	item_t       item_s1;
	logic        out_valid_q;
	logic [31:0] dts_q, pts_q;
	status_t     status_q;

	logic        out_free, fire, accept;
	verdict_t    verdict;
	logic [31:0] dts_c, pts_c;

	assign out_free = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q       <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_TIMESTAMP_HALVING: cfg_q.ts_halving  <= cfg_data;
					CFG_OFFSET_HALVING:    cfg_q.off_halving <= cfg_data;
					default: ;
				endcase
			end
			if (accept)
				valid_s1 <= 1'b1;
			else if (fire)
				valid_s1 <= 1'b0;
			if (fire)
				out_valid_q <= verdict.has_result;
			else
				out_valid_q <= out_valid_q && out_stall;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.command   <= command;
			item_s1.frame_id  <= frame_id;
			item_s1.skip_flag <= skip_flag;
			item_s1.frame_gap <= frame_gap;
			item_s1.dts_in    <= dts_in;
			item_s1.pts_in    <= pts_in;
		end
		if (fire) begin
			dts_q    <= dts_c;
			pts_q    <= pts_c;
			status_q <= verdict.status;
		end
	end

	ets_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.item    (item_s1),
		.cfg     (cfg_q),
		.verdict (verdict)
	);

	ets_ts_calc u_calc (
		.item    (item_s1),
		.verdict (verdict),
		.cfg     (cfg_q),
		.dts     (dts_c),
		.pts     (pts_c)
	);

	assign out_valid = out_valid_q;
	assign dts_out   = $signed(dts_q);
	assign pts_out   = $signed(pts_q);
	assign status    = status_q;

endmodule

`default_nettype wire

// File: hdl/ets_core.sv
`default_nettype none

module ets_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  wire ets_pkg::item_t    item,
	input  wire ets_pkg::cfg_t     cfg,
	output ets_pkg::verdict_t      verdict
);
	import ets_pkg::*;

	logic [31:0]       skipped_q;
	logic [31:0]       out_count_q;
	logic [31:0]       gap_offset_q;

	logic [31:0]       gap_num_q [QUEUE_DEPTH];
	logic [15:0]       gap_len_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] gap_head_q, gap_tail_q;
	logic [FILL_W-1:0] gap_fill_q;

	logic [31:0]       bump_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] bump_head_q, bump_tail_q;
	logic [FILL_W-1:0] bump_fill_q;

	logic        is_enc;
	logic [31:0] skipped_nx;
	logic        bump_req, bump_full, bump_push;
	logic        gap_req, gap_full, gap_push;
	logic        overflow;
	logic [31:0] gap_head_num, bump_head_num;
	logic        gap_due, gap_hit, gap_miss;
	logic        bump_due, bump_hit, bump_miss;
	logic [31:0] offset_nx;

	always_comb begin
		is_enc     = item.command == CMD_ENCODED;

		bump_full = bump_fill_q == FILL_W'(QUEUE_DEPTH);
		bump_req  = !is_enc && item.skip_flag;
		bump_push = bump_req && !bump_full;
		gap_full  = gap_fill_q == FILL_W'(QUEUE_DEPTH);
		gap_req   = !is_enc && (item.frame_gap != 16'd0);
		gap_push  = gap_req && !gap_full;
		overflow  = (bump_req && bump_full) || (gap_req && gap_full);

		// only frame events count skips
		skipped_nx = skipped_q + {31'b0, bump_req};

		gap_head_num = gap_num_q[gap_head_q];
		gap_due  = is_enc && (gap_fill_q != '0) && (gap_head_num <= out_count_q);
		gap_hit  = gap_due && (gap_head_num == out_count_q);
		gap_miss = gap_due && !gap_hit;

		bump_head_num = bump_q[bump_head_q];
		bump_due  = is_enc && !gap_miss && (bump_fill_q != '0)
			&& (bump_head_num <= out_count_q);
		bump_hit  = bump_due && (bump_head_num == out_count_q);
		bump_miss = bump_due && !bump_hit;

		offset_nx = gap_offset_q + (gap_hit ? {16'b0, gap_len_q[gap_head_q]} : 32'd0);

		verdict.has_result = is_enc || overflow;
		verdict.encoded    = is_enc;
		verdict.bump_hit   = bump_hit;
		verdict.offset     = cfg.off_halving ? {1'b0, offset_nx[31:1]} : offset_nx;
		if (!is_enc)
			verdict.status = ST_OVERFLOW;
		else if (gap_miss)
			verdict.status = ST_MISSED_GAP;
		else if (bump_miss)
			verdict.status = ST_MISSED_BUMP;
		else
			verdict.status = ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skipped_q    <= '0;
			out_count_q  <= '0;
			gap_offset_q <= '0;
			gap_head_q   <= '0;
			gap_tail_q   <= '0;
			gap_fill_q   <= '0;
			bump_head_q  <= '0;
			bump_tail_q  <= '0;
			bump_fill_q  <= '0;
		end else if (fire) begin
			skipped_q    <= skipped_nx;
			gap_offset_q <= offset_nx;
			if (is_enc)
				out_count_q <= out_count_q + 32'd1;
			if (gap_push) begin
				gap_tail_q <= next_ptr(gap_tail_q);
				gap_fill_q <= gap_fill_q + 1'b1;
			end else if (gap_due) begin
				gap_head_q <= next_ptr(gap_head_q);
				gap_fill_q <= gap_fill_q - 1'b1;
			end
			if (bump_push) begin
				bump_tail_q <= next_ptr(bump_tail_q);
				bump_fill_q <= bump_fill_q + 1'b1;
			end else if (bump_due) begin
				bump_head_q <= next_ptr(bump_head_q);
				bump_fill_q <= bump_fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && gap_push) begin
			gap_num_q[gap_tail_q] <= item.frame_id - skipped_nx;
			gap_len_q[gap_tail_q] <= item.frame_gap;
		end
		if (fire && bump_push)
			bump_q[bump_tail_q] <= item.frame_id - skipped_q;
	end

	a_gap_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		gap_fill_q <= FILL_W'(QUEUE_DEPTH))
		else $error("gap queue fill past depth");

	a_bump_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bump_fill_q <= FILL_W'(QUEUE_DEPTH))
		else $error("bump queue fill past depth");

	a_miss_gap_keeps_bump: assert property (@(posedge clk) disable iff (!arst_n)
		fire && gap_miss |=> bump_fill_q == $past(bump_fill_q))
		else $error("bump queue touched on missed gap");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire && is_enc |=> out_count_q == $past(out_count_q) + 32'd1)
		else $error("output count did not step");

endmodule

`default_nettype wire

// File: hdl/ets_ts_calc.sv
`default_nettype none

module ets_ts_calc (
	input  wire ets_pkg::item_t    item,
	input  wire ets_pkg::verdict_t verdict,
	input  wire ets_pkg::cfg_t     cfg,
	output logic [31:0]            dts,
	output logic [31:0]            pts
);
	import ets_pkg::*;

	logic [2:0]  dts_inc;
	logic [1:0]  pts_inc;
	logic [31:0] dts_sum, pts_sum;

	always_comb begin
		// dts: initial offset plus bump, both doubled under timestamp halving; pts: bump only, doubled under offset halving
		if (cfg.ts_halving)
			dts_inc = verdict.bump_hit ? 3'd4 : 3'd2;
		else
			dts_inc = verdict.bump_hit ? 3'd2 : 3'd1;
		if (verdict.bump_hit)
			pts_inc = cfg.off_halving ? 2'd2 : 2'd1;
		else
			pts_inc = 2'd0;

		dts_sum = item.dts_in + {29'b0, dts_inc} + verdict.offset;
		pts_sum = item.pts_in + {30'b0, pts_inc} + verdict.offset;

		if (!verdict.encoded) begin
			dts = '0;
			pts = '0;
		end else if (cfg.ts_halving) begin
			dts = halve_signed(dts_sum);
			pts = halve_signed(pts_sum);
		end else begin
			dts = dts_sum;
			pts = pts_sum;
		end
	end

endmodule

`default_nettype wire
